// ===== design/sst_pkg.sv =====
package sst_pkg;

  // fixed field widths of the token report
  localparam int unsigned POS_W = 16;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned SYM_W = 16;

  // default sizing
  localparam int unsigned MAX_LEXEME_DEF  = 49;
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // number of leading word characters kept for keyword matching
  localparam int unsigned PREFIX_DEPTH = 7;

  // result queue depth, holds two reports of one item plus slack
  localparam int unsigned Q_DEPTH = 4;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [47:0] KW_SCALAR  = "scalar";
  localparam logic [55:0] KW_FOREACH = "foreach";

  typedef enum logic [2:0] {
    K_KEY  = 3'd0,
    K_ID   = 3'd1,
    K_VAR  = 3'd2,
    K_OP   = 3'd3,
    K_SPEC = 3'd4,
    K_NUM  = 3'd5,
    K_ARGS = 3'd6,
    K_EOF  = 3'd7
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_file;
  } tok_in_t;

  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] start_line;
    logic [POS_W-1:0] start_column;
    logic [LEN_W-1:0] length;
    logic             too_long;
    logic [SYM_W-1:0] symbol_chars;
    logic             keyword_index;
    logic             last;
  } tok_out_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" ||
           c == "=" || c == "<" || c == ">" || c == "!";
  endfunction

  function automatic logic is_spec(logic [7:0] c);
    return c == ";" || c == ":" || c == "." || c == "(" || c == ")" ||
           c == "[" || c == "]" || c == "{" || c == "}";
  endfunction

endpackage

// ===== design/script_source_tokenizer_core.sv =====
// streaming source tokenizer
// input channel: one transaction per source byte (ch) or an end-of-file mark
//   (end_of_file set, ch ignored); accepted when in_valid_i is high and
//   in_stall_o is low
// output channel: one transaction per token report; an item that ends a
//   pending token and is itself a special character or end of file gives
//   two reports, the second one flagged last (a lone report is always last)
// timing: an accepted item is scanned in the cycle it is accepted and its
//   reports enter the result queue, one report leaving it per cycle while
//   out_stall_i is low; one item per clock is taken as long as reports drain
// a four-entry result queue decouples the sides: input is stalled only while
//   fewer than two queue entries are free, so a stalled receiver backs up
//   into the input once three reports are waiting
// reset: scanner idle, line and column at 1, queue empty, no report pending
// whitespace and comments produce no reports but still take one item each
module script_source_tokenizer_core
  import sst_pkg::*;
#(
  parameter int unsigned MAX_LEXEME  = MAX_LEXEME_DEF,
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tok_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tok_out_t out_data_o
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);
  localparam int unsigned PIX_W = $clog2(PREFIX_DEPTH);

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_DOLLAR, M_VAR, M_NUM, M_OP, M_AT, M_COMMENT
  } mode_e;

  // scanner state
  mode_e                  mode_q, mode_d;
  logic [COORD_WIDTH-1:0] line_q, line_d;
  logic [COORD_WIDTH-1:0] col_q, col_d;
  logic [COORD_WIDTH-1:0] tline_q, tline_d;
  logic [COORD_WIDTH-1:0] tcol_q, tcol_d;
  logic [LEN_W-1:0]       tlen_q, tlen_d;
  logic                   tover_q, tover_d;
  logic [7:0]             hop_q, hop_d;
  logic [7:0]             pfx_q [PREFIX_DEPTH];
  logic [7:0]             pfx_d [PREFIX_DEPTH];

  // result queue
  tok_out_t               fifo_q [Q_DEPTH];
  logic [PTR_W-1:0]       wptr_q, wptr_d;
  logic [PTR_W-1:0]       rptr_q, rptr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  tok_out_t               rv [2];
  logic [1:0]             nres;
  logic                   in_acc, out_acc;

  function automatic tok_out_t pack_res(kind_e k, logic [COORD_WIDTH-1:0] ln,
                                        logic [COORD_WIDTH-1:0] cl,
                                        logic [LEN_W-1:0] len, logic over,
                                        logic [SYM_W-1:0] sym, logic kwi);
    tok_out_t r;
    r.kind          = k;
    r.start_line    = POS_W'(ln);
    r.start_column  = POS_W'(cl);
    r.length        = len;
    r.too_long      = over;
    r.symbol_chars  = sym;
    r.keyword_index = kwi;
    r.last          = 1'b0;
    return r;
  endfunction

  // room for the two reports a single item may cause
  assign in_stall_o  = cnt_q > CNT_W'(Q_DEPTH - 2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_data_o  = fifo_q[rptr_q];

  // one pass of the scanner over the accepted item
  always_comb begin
    logic [7:0] c;
    logic       eof;
    logic       flush, idle, app, col_only, beg;
    logic       em_op2, em_args, em_spec;
    logic       kw_s, kw_f;

    c        = in_data_i.ch;
    eof      = in_data_i.end_of_file;
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    tline_d  = tline_q;
    tcol_d   = tcol_q;
    tlen_d   = tlen_q;
    tover_d  = tover_q;
    hop_d    = hop_q;
    pfx_d    = pfx_q;
    rv[0]    = '0;
    rv[1]    = '0;
    nres     = '0;
    flush    = 1'b0;
    idle     = 1'b0;
    app      = 1'b0;
    col_only = 1'b0;
    beg      = 1'b0;
    em_op2   = 1'b0;
    em_args  = 1'b0;
    em_spec  = 1'b0;
    kw_s     = 1'b0;
    kw_f     = 1'b0;

    if (eof) begin
      flush = 1'b1;
    end else begin
      unique case (mode_q)
        M_COMMENT: begin
          if (c == CH_LF) idle = 1'b1;
          else col_only = 1'b1;
        end
        M_WORD, M_VAR: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) app = 1'b1;
          else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_DOLLAR: begin
          if (is_alpha(c) || c == CH_UNDER) begin
            app    = 1'b1;
            mode_d = M_VAR;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(c)) app = 1'b1;
          else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_OP: begin
          if (is_op(c)) begin
            app    = 1'b1;
            em_op2 = 1'b1;
            mode_d = M_IDLE;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_AT: begin
          if (c == CH_UNDER) begin
            app     = 1'b1;
            em_args = 1'b1;
            mode_d  = M_IDLE;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        default: idle = 1'b1;
      endcase
    end

    // report whatever token was pending, before a new one is started
    if (flush) begin
      kw_s = !tover_q && tlen_q == LEN_W'(6) &&
             {pfx_q[0], pfx_q[1], pfx_q[2], pfx_q[3], pfx_q[4], pfx_q[5]} == KW_SCALAR;
      kw_f = !tover_q && tlen_q == LEN_W'(7) &&
             {pfx_q[0], pfx_q[1], pfx_q[2], pfx_q[3], pfx_q[4], pfx_q[5],
              pfx_q[6]} == KW_FOREACH;
      case (mode_q)
        M_WORD: begin
          rv[0] = pack_res((kw_s || kw_f) ? K_KEY : K_ID, tline_q, tcol_q, tlen_q,
                           tover_q, '0, kw_f);
          nres  = 2'd1;
        end
        M_DOLLAR: begin
          rv[0] = pack_res(K_SPEC, tline_q, tcol_q, tlen_q, tover_q,
                           {CH_DOLLAR, 8'h00}, 1'b0);
          nres  = 2'd1;
        end
        M_VAR: begin
          rv[0] = pack_res(K_VAR, tline_q, tcol_q, tlen_q, tover_q, '0, 1'b0);
          nres  = 2'd1;
        end
        M_NUM: begin
          rv[0] = pack_res(K_NUM, tline_q, tcol_q, tlen_q, tover_q, '0, 1'b0);
          nres  = 2'd1;
        end
        M_OP: begin
          rv[0] = pack_res(K_OP, tline_q, tcol_q, tlen_q, tover_q,
                           {hop_q, 8'h00}, 1'b0);
          nres  = 2'd1;
        end
        M_AT: begin
          rv[0] = pack_res(K_SPEC, tline_q, tcol_q, tlen_q, tover_q,
                           {CH_AT, 8'h00}, 1'b0);
          nres  = 2'd1;
        end
        default: ;
      endcase
      mode_d = M_IDLE;
    end

    // idle scanner sees the byte, possibly the one that ended a token
    if (idle) begin
      mode_d = M_IDLE;
      if (c == CH_LF) begin
        if (line_q != '1) line_d = line_q + 1'b1;
        col_d = COORD_WIDTH'(1);
      end else if (c == CH_AT) begin
        beg    = 1'b1;
        mode_d = M_AT;
      end else if (c == CH_HASH) begin
        mode_d   = M_COMMENT;
        col_only = 1'b1;
      end else if (c == CH_DOLLAR) begin
        beg    = 1'b1;
        mode_d = M_DOLLAR;
      end else if (is_alpha(c) || c == CH_UNDER) begin
        beg    = 1'b1;
        mode_d = M_WORD;
      end else if (is_digit(c)) begin
        beg    = 1'b1;
        mode_d = M_NUM;
      end else if (is_op(c)) begin
        beg    = 1'b1;
        mode_d = M_OP;
        hop_d  = c;
      end else if (is_spec(c)) begin
        beg     = 1'b1;
        em_spec = 1'b1;
      end else begin
        // blanks and bytes that start nothing
        col_only = 1'b1;
      end
      app = app | beg;
    end

    if (beg) begin
      tline_d = line_q;
      tcol_d  = col_q;
      tlen_d  = '0;
      tover_d = 1'b0;
    end

    if (app) begin
      if (tlen_d < LEN_W'(MAX_LEXEME)) begin
        if (tlen_d < LEN_W'(PREFIX_DEPTH)) pfx_d[tlen_d[PIX_W-1:0]] = c;
        tlen_d = tlen_d + 1'b1;
      end else begin
        tover_d = 1'b1;
      end
    end

    // every consumed byte other than a line feed moves the column
    if ((app || col_only) && col_q != '1) col_d = col_q + 1'b1;

    if (em_op2) begin
      rv[nres[0]] = pack_res(K_OP, tline_d, tcol_d, tlen_d, tover_d, {hop_q, c}, 1'b0);
      nres = nres + 2'd1;
    end
    if (em_args) begin
      rv[nres[0]] = pack_res(K_ARGS, tline_d, tcol_d, tlen_d, tover_d, '0, 1'b0);
      nres = nres + 2'd1;
    end
    if (em_spec) begin
      rv[nres[0]] = pack_res(K_SPEC, tline_d, tcol_d, tlen_d, tover_d, {c, 8'h00}, 1'b0);
      nres = nres + 2'd1;
    end
    if (eof) begin
      rv[nres[0]] = pack_res(K_EOF, line_q, col_q, '0, 1'b0, '0, 1'b0);
      nres = nres + 2'd1;
    end

    if (nres == 2'd1) rv[0].last = 1'b1;
    if (nres == 2'd2) rv[1].last = 1'b1;
  end

  // queue pointers and occupancy
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (in_acc) begin
      wptr_d = wptr_q + PTR_W'(nres);
      cnt_d  = cnt_d + CNT_W'(nres);
    end
    if (out_acc) begin
      rptr_d = rptr_q + 1'b1;
      cnt_d  = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      line_q  <= COORD_WIDTH'(1);
      col_q   <= COORD_WIDTH'(1);
      tline_q <= '0;
      tcol_q  <= '0;
      tlen_q  <= '0;
      tover_q <= 1'b0;
      hop_q   <= '0;
      wptr_q  <= '0;
      rptr_q  <= '0;
      cnt_q   <= '0;
    end else begin
      if (in_acc) begin
        mode_q  <= mode_d;
        line_q  <= line_d;
        col_q   <= col_d;
        tline_q <= tline_d;
        tcol_q  <= tcol_d;
        tlen_q  <= tlen_d;
        tover_q <= tover_d;
        hop_q   <= hop_d;
      end
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pfx_q <= pfx_d;
      if (nres != 2'd0) fifo_q[wptr_q] <= rv[0];
      if (nres == 2'd2) fifo_q[wptr_q + 1'b1] <= rv[1];
    end
  end

endmodule

// ===== dv/script_source_tokenizer_core_test.sv =====
`timescale 1ns / 1ps

module script_source_tokenizer_core_test
  import sst_pkg::*;
;

  // character sets used to build random source text
  localparam string OP_CHARS   = "+-*/=<>!";
  localparam string SPEC_CHARS = ";:.()[]{}";

  // clock, reset and block ports
  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  tok_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tok_out_t out_data_o;

  // idle_on enables random sender gaps and receiver stalls
  logic     idle_on     = 1'b0;
  int       sent        = 0;
  int       stall_left  = 0;
  int       stall_roll;
  tok_in_t  script_q[$];

  // scanner model and store of pending token reports
  class token_scoreboard;
    typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_DOLLAR, SCAN_VAR,
      SCAN_NUM, SCAN_OP, SCAN_AT, SCAN_COMMENT
    } scan_mode_e;

    scan_mode_e       mode;
    logic [POS_W-1:0] cur_line, cur_col, tok_line, tok_col;
    logic [LEN_W-1:0] tok_len;
    logic             tok_over;
    logic [7:0]       held_op;
    logic [7:0]       prefix [PREFIX_DEPTH];
    tok_out_t         step_reports[$];
    tok_out_t         expected_reports[$];
    int               errors;

    function new();
      mode     = SCAN_IDLE;
      cur_line = 1;
      cur_col  = 1;
      tok_line = '0;
      tok_col  = '0;
      tok_len  = '0;
      tok_over = 1'b0;
      held_op  = '0;
      foreach (prefix[i]) prefix[i] = '0;
      errors   = 0;
    endfunction

    function bit in_chars(logic [7:0] c, string set);
      int i;
      for (i = 0; i < set.len(); i++) if (set[i] == c) return 1'b1;
      return 1'b0;
    endfunction

    function bit is_letter(logic [7:0] c);
      return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function bit is_numeral(logic [7:0] c);
      return c inside {["0":"9"]};
    endfunction

    function bit is_word_char(logic [7:0] c);
      return is_letter(c) || is_numeral(c) || c == CH_UNDER;
    endfunction

    // column and line saturate at the all-ones coordinate
    function void advance_column();
      if (cur_col != '1) cur_col++;
    endfunction

    function void push_report(kind_e k, logic [POS_W-1:0] ln, logic [POS_W-1:0] cl,
                              logic [LEN_W-1:0] len, logic over,
                              logic [SYM_W-1:0] sym, logic kwi);
      tok_out_t r;
      r.kind          = k;
      r.start_line    = ln;
      r.start_column  = cl;
      r.length        = len;
      r.too_long      = over;
      r.symbol_chars  = sym;
      r.keyword_index = kwi;
      r.last          = 1'b0;
      step_reports.push_back(r);
    endfunction

    function void report_token(kind_e k, logic [SYM_W-1:0] sym, logic kwi);
      push_report(k, tok_line, tok_col, tok_len, tok_over, sym, kwi);
    endfunction

    function void open_token(scan_mode_e m);
      tok_line = cur_line;
      tok_col  = cur_col;
      tok_len  = '0;
      tok_over = 1'b0;
      mode     = m;
    endfunction

    // length saturates, only the leading characters are kept for keywords
    function void add_char(logic [7:0] c);
      if (tok_len < MAX_LEXEME_DEF) begin
        if (tok_len < PREFIX_DEPTH) prefix[tok_len] = c;
        tok_len++;
      end else begin
        tok_over = 1'b1;
      end
      advance_column();
    endfunction

    function void report_word();
      if (!tok_over && tok_len == 6 &&
          {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4], prefix[5]} == KW_SCALAR)
        report_token(K_KEY, '0, 1'b0);
      else if (!tok_over && tok_len == 7 &&
               {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4], prefix[5],
                prefix[6]} == KW_FOREACH)
        report_token(K_KEY, '0, 1'b1);
      else
        report_token(K_ID, '0, 1'b0);
    endfunction

    // report whatever token is open when a terminator shows up
    function void flush_token();
      case (mode)
        SCAN_WORD:   report_word();
        SCAN_DOLLAR: report_token(K_SPEC, {CH_DOLLAR, 8'h00}, 1'b0);
        SCAN_VAR:    report_token(K_VAR, '0, 1'b0);
        SCAN_NUM:    report_token(K_NUM, '0, 1'b0);
        SCAN_OP:     report_token(K_OP, {held_op, 8'h00}, 1'b0);
        SCAN_AT:     report_token(K_SPEC, {CH_AT, 8'h00}, 1'b0);
        default: ;
      endcase
      mode = SCAN_IDLE;
    endfunction

    function void scan_idle(logic [7:0] c);
      if (c == CH_LF) begin
        if (cur_line != '1) cur_line++;
        cur_col = 1;
      end else if (c == CH_AT) begin
        open_token(SCAN_AT);
        add_char(c);
      end else if (c == CH_HASH) begin
        mode = SCAN_COMMENT;
        advance_column();
      end else if (c == CH_DOLLAR) begin
        open_token(SCAN_DOLLAR);
        add_char(c);
      end else if (is_letter(c) || c == CH_UNDER) begin
        open_token(SCAN_WORD);
        add_char(c);
      end else if (is_numeral(c)) begin
        open_token(SCAN_NUM);
        add_char(c);
      end else if (in_chars(c, "+-*/=<>!")) begin
        open_token(SCAN_OP);
        held_op = c;
        add_char(c);
      end else if (in_chars(c, ";:.()[]{}")) begin
        open_token(SCAN_IDLE);
        add_char(c);
        report_token(K_SPEC, {c, 8'h00}, 1'b0);
      end else begin
        // blanks and unknown bytes only move the column
        advance_column();
      end
    endfunction

    function void scan(logic [7:0] c);
      case (mode)
        SCAN_COMMENT: begin
          if (c == CH_LF) begin
            mode = SCAN_IDLE;
            scan_idle(c);
          end else begin
            advance_column();
          end
          return;
        end
        SCAN_WORD, SCAN_VAR: begin
          if (is_word_char(c)) begin
            add_char(c);
            return;
          end
        end
        SCAN_DOLLAR: begin
          if (is_letter(c) || c == CH_UNDER) begin
            add_char(c);
            mode = SCAN_VAR;
            return;
          end
        end
        SCAN_NUM: begin
          if (is_numeral(c)) begin
            add_char(c);
            return;
          end
        end
        SCAN_OP: begin
          if (in_chars(c, "+-*/=<>!")) begin
            add_char(c);
            report_token(K_OP, {held_op, c}, 1'b0);
            mode = SCAN_IDLE;
            return;
          end
        end
        SCAN_AT: begin
          if (c == CH_UNDER) begin
            add_char(c);
            report_token(K_ARGS, '0, 1'b0);
            mode = SCAN_IDLE;
            return;
          end
        end
        default: begin
          mode = SCAN_IDLE;
          scan_idle(c);
          return;
        end
      endcase
      // terminator ends the open token and is scanned again from idle
      flush_token();
      scan_idle(c);
    endfunction

    // accepted input transaction: work out the reports it causes
    function void note_byte(tok_in_t item);
      tok_out_t r;
      int       i;
      step_reports.delete();
      if (item.end_of_file) begin
        if (mode == SCAN_COMMENT) mode = SCAN_IDLE;
        flush_token();
        push_report(K_EOF, cur_line, cur_col, '0, 1'b0, '0, 1'b0);
      end else begin
        scan(item.ch);
      end
      for (i = 0; i < step_reports.size(); i++) begin
        r      = step_reports[i];
        r.last = (i == step_reports.size() - 1);
        expected_reports.push_back(r);
      end
    endfunction

    function bit field_differs(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // accepted output transaction: compare with the oldest pending report
    function void check_report(tok_out_t got);
      tok_out_t want;
      bit       bad;
      if (expected_reports.size() == 0) begin
        $display("%0t: report with none pending, expected nothing, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      bad  = 1'b0;
      bad |= field_differs("kind", 16'(want.kind), 16'(got.kind));
      bad |= field_differs("start_line", want.start_line, got.start_line);
      bad |= field_differs("start_column", want.start_column, got.start_column);
      bad |= field_differs("length", 16'(want.length), 16'(got.length));
      bad |= field_differs("too_long", 16'(want.too_long), 16'(got.too_long));
      bad |= field_differs("symbol_chars", want.symbol_chars, got.symbol_chars);
      bad |= field_differs("keyword_index", 16'(want.keyword_index),
                           16'(got.keyword_index));
      bad |= field_differs("last", 16'(want.last), 16'(got.last));
      if (bad) errors++;
    endfunction
  endclass

  token_scoreboard sb = new();

  script_source_tokenizer_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // both channels are sampled at the rising edge, before any drive of that edge lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_report(out_data_o);
    end
  end

  // receiver stalls in runs: mostly short, a few long
  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left == 0) begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 60) begin
        out_stall_i <= 1'b0;
        stall_left = $urandom_range(1, 6);
      end else if (stall_roll < 92) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(8, 40);
      end
    end else begin
      stall_left--;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_byte(logic [7:0] c, logic eof);
    tok_in_t item;
    item.ch          = c;
    item.end_of_file = eof;
    script_q.push_back(item);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endfunction

  // lead characters are letters or underscore, later ones may be digits
  function automatic logic [7:0] word_char(bit lead);
    int roll;
    roll = $urandom_range(0, lead ? 52 : 62);
    if (roll < 26) return "a" + 8'(roll);
    if (roll < 52) return "A" + 8'(roll - 26);
    if (roll == 52) return CH_UNDER;
    return "0" + 8'(roll - 53);
  endfunction

  function automatic void add_word(int n);
    int i;
    add_byte(word_char(1'b1), 1'b0);
    for (i = 1; i < n; i++) add_byte(word_char(1'b0), 1'b0);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 4))
      0:       return 8'h09;
      1:       return 8'h0B;
      2:       return 8'h0C;
      3:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  // one random piece of source text: mostly well-formed tokens, some noise
  function automatic void add_fragment();
    int         pick, n, i;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      n = $urandom_range(0, 19);
      if (n < 2) add_text("scalar");
      else if (n < 4) add_text("foreach");
      else if (n == 4) begin
        // near misses of the keywords
        case ($urandom_range(0, 3))
          0:       add_text("scala");
          1:       add_text("scalars");
          2:       add_text("forEach");
          default: add_text("foreachx");
        endcase
      end
      else if (n < 7) add_word($urandom_range(47, 56));
      else add_word($urandom_range(1, 9));
    end else if (pick < 35) begin
      add_byte(CH_DOLLAR, 1'b0);
      add_word(($urandom_range(0, 9) == 0) ? $urandom_range(47, 56) : $urandom_range(1, 8));
    end else if (pick < 45) begin
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(47, 56) : $urandom_range(1, 6);
      for (i = 0; i < n; i++) add_byte("0" + 8'($urandom_range(0, 9)), 1'b0);
    end else if (pick < 55) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) add_byte(OP_CHARS[$urandom_range(0, 7)], 1'b0);
    end else if (pick < 62) begin
      add_byte(SPEC_CHARS[$urandom_range(0, 8)], 1'b0);
    end else if (pick < 68) begin
      add_byte(CH_AT, 1'b0);
      if ($urandom_range(0, 4) < 3) add_byte(CH_UNDER, 1'b0);
    end else if (pick < 72) begin
      add_byte(CH_DOLLAR, 1'b0);
    end else if (pick < 80) begin
      // comment body is any byte but a line feed
      add_byte(CH_HASH, 1'b0);
      n = $urandom_range(0, 10);
      for (i = 0; i < n; i++) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_LF) c = 8'hFF;
        add_byte(c, 1'b0);
      end
      if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(0, 255)), 1'b1);
      else add_byte(CH_LF, 1'b0);
    end else if (pick < 86) begin
      add_byte(CH_LF, 1'b0);
    end else if (pick < 93) begin
      add_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      add_byte(8'($urandom_range(0, 255)), 1'b1);
    end
    // half the time the next fragment follows directly and acts as terminator
    n = $urandom_range(0, 19);
    if (n < 7) add_byte(blank_char(), 1'b0);
    else if (n < 10) add_byte(CH_LF, 1'b0);
  endfunction

  // one input transaction, optionally after a gap; payload held while stalled
  task automatic send_item(tok_in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic pump_items();
    while (script_q.size() != 0) send_item(script_q.pop_front());
  endtask

  task automatic random_items(int n);
    int target;
    target = sent + n;
    while (sent < target) begin
      add_fragment();
      pump_items();
    end
  endtask

  // stop sending until every pending report is back, then leave the block idle
  task automatic settle();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    @(negedge clk_i);
    while (sb.expected_reports.size() != 0 && waited < 2000) begin
      @(negedge clk_i);
      waited++;
    end
    if (sb.expected_reports.size() != 0) begin
      $display("%0t: %0d reports expected, actual none", $time, sb.expected_reports.size());
      sb.errors++;
      sb.expected_reports.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: keywords, reprocessed terminators, two-char operator,
    // number then word, lone dollar, args array, comment with high byte,
    // lone at flushed by end of file, unknown byte, bare end of file
    add_text("scalar;foreach<=9x$@_#");
    add_byte(8'hFF, 1'b0);
    add_byte(CH_LF, 1'b0);
    add_byte(CH_AT, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    pump_items();
    settle();

    // random text with gaps and stalls, then a full drain
    idle_on <= 1'b1;
    random_items(500);
    settle();

    // back-to-back stretch with no idling
    idle_on <= 1'b0;
    random_items(300);

    idle_on <= 1'b1;
    random_items(500);
    settle();

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/sst_pkg.sv
design/script_source_tokenizer_core.sv
dv/script_source_tokenizer_core_test.sv
